// ===== hdl/hss_pkg.sv =====
// shared constants, table entry type and controller/datapath interface types
package hss_pkg;

   localparam int SEGMENT_DEPTH = 128;
   localparam int TIME_BITS     = 16;

   localparam int ADDR_W = $clog2(SEGMENT_DEPTH);
   localparam int PTR_W  = $clog2(SEGMENT_DEPTH + 1);

   // fixed field widths of the transaction ports
   localparam int KIND_W  = 2;
   localparam int IDX_W   = 7;
   localparam int FTIME_W = 16;
   localparam int CODE_W  = 2;
   localparam int LEN_W   = 8;
   localparam int CUR_W   = 7;

   localparam logic [CODE_W-1:0] FWD_BIT = 2'b01;
   localparam logic [CODE_W-1:0] REV_BIT = 2'b10;

   typedef struct packed {
      logic [TIME_BITS-1:0] on_ticks;
      logic [TIME_BITS-1:0] off_ticks;
      logic [TIME_BITS-1:0] reps;
      logic [CODE_W-1:0]    code;
   } seg_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_WRITE,
      OP_PLAY,
      OP_STOP,
      OP_TICK_DEC,
      OP_TICK_EVAL,
      OP_SCAN_EVAL,
      OP_FINISH
   } op_type;

   typedef struct packed {
      op_type op;
      logic   accept;
   } cmd_type;

   typedef struct packed {
      logic busy;
      logic ticks_gt1;
      logic play_ok;
      logic tick_hold;
      logic seg_started;
      logic at_end;
   } status_type;

endpackage

// ===== hdl/hss_ctrl.sv =====
// sequencing controller: transaction handshake, item decode and step ordering
module hss_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_kind,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  hss_pkg::status_type  status,
   output hss_pkg::cmd_type     cmd
);
   import hss_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TICK_WAIT,
      ST_TICK_EVAL,
      ST_SCAN_WAIT,
      ST_SCAN_EVAL,
      ST_FINISH
   } state_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_TICK,
      KIND_WRITE,
      KIND_PLAY,
      KIND_STOP
   } kind_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      cmd.op       = OP_NONE;
      cmd.accept   = 1'b0;
      rsp_valid_in = (rsp_valid_ff && !rsp_stall) ? 1'b0 : rsp_valid_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               unique case (kind_type'(req_kind))
                  KIND_TICK: begin
                     if (status.busy && status.ticks_gt1) begin
                        cmd.op   = OP_TICK_DEC;
                        state_in = ST_FINISH;
                     end else if (status.busy) begin
                        // phase expires: the current segment is needed
                        state_in = ST_TICK_WAIT;
                     end else begin
                        state_in = ST_FINISH;
                     end
                  end
                  KIND_WRITE: begin
                     cmd.op   = OP_WRITE;
                     state_in = ST_FINISH;
                  end
                  KIND_PLAY: begin
                     if (status.play_ok) begin
                        cmd.op   = OP_PLAY;
                        state_in = ST_SCAN_WAIT;
                     end else begin
                        state_in = ST_FINISH;
                     end
                  end
                  KIND_STOP: begin
                     cmd.op   = OP_STOP;
                     state_in = ST_FINISH;
                  end
                  default: state_in = ST_FINISH;
               endcase
            end
         end
         ST_TICK_WAIT: state_in = ST_TICK_EVAL;
         ST_TICK_EVAL: begin
            cmd.op   = OP_TICK_EVAL;
            state_in = status.tick_hold ? ST_FINISH : ST_SCAN_WAIT;
         end
         ST_SCAN_WAIT: state_in = ST_SCAN_EVAL;
         ST_SCAN_EVAL: begin
            cmd.op   = OP_SCAN_EVAL;
            state_in = (status.at_end || status.seg_started) ? ST_FINISH : ST_SCAN_WAIT;
         end
         ST_FINISH: begin
            if (slot_free) begin
               cmd.op       = OP_FINISH;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTH
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("controller stayed idle after a request transaction");
`endif

endmodule

// ===== hdl/hss_datapath.sv =====
// segment table, playback counters, drive pins and result register
module hss_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  hss_pkg::cmd_type              cmd,
   output hss_pkg::status_type           status,
   input  logic [hss_pkg::IDX_W-1:0]     req_seg_index,
   input  logic [hss_pkg::FTIME_W-1:0]   req_on_time,
   input  logic [hss_pkg::FTIME_W-1:0]   req_off_time,
   input  logic [hss_pkg::FTIME_W-1:0]   req_repeat_count,
   input  logic [hss_pkg::CODE_W-1:0]    req_drive_code,
   input  logic [hss_pkg::LEN_W-1:0]     req_play_length,
   input  logic                          csr_wr_en,
   input  logic                          csr_wr_data,
   output logic                          rsp_pin_forward,
   output logic                          rsp_pin_reverse,
   output logic                          rsp_busy_res,
   output logic                          rsp_accepted,
   output logic [hss_pkg::CUR_W-1:0]     rsp_current_segment
);
   import hss_pkg::*;

   seg_type seg_mem [SEGMENT_DEPTH];
   seg_type rd_ff;
   seg_type wr_seg;
   logic    idx_ok;
   logic    mem_we;

   logic                 mode_ff;
   logic                 busy_ff, busy_in;
   logic [PTR_W-1:0]     ptr_ff, ptr_in;
   logic [PTR_W-1:0]     end_ff, end_in;
   logic                 phase_on_ff, phase_on_in;
   logic [TIME_BITS-1:0] ticks_ff, ticks_in;
   logic [TIME_BITS-1:0] pulses_ff, pulses_in;
   logic [CODE_W-1:0]    pins_ff, pins_in;
   logic                 acc_ff, acc_in;
   logic                 tick_hold, seg_started, at_end, do_relax;

   logic                 out_fwd_ff, out_rev_ff, out_busy_ff, out_acc_ff;
   logic [CUR_W-1:0]     out_cur_ff;

   assign idx_ok = 32'(req_seg_index) < 32'(SEGMENT_DEPTH);
   assign mem_we = (cmd.op == OP_WRITE) && idx_ok;
   assign at_end = ptr_ff >= end_ff;

   always_comb begin
      wr_seg.on_ticks  = TIME_BITS'(req_on_time);
      wr_seg.off_ticks = TIME_BITS'(req_off_time);
      wr_seg.reps      = TIME_BITS'(req_repeat_count);
      wr_seg.code      = req_drive_code;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         seg_mem[ADDR_W'(req_seg_index)] <= wr_seg;
      end
      rd_ff <= seg_mem[ptr_ff[ADDR_W-1:0]];
   end

   always_comb begin
      status.busy        = busy_ff;
      status.ticks_gt1   = ticks_ff > TIME_BITS'(1);
      status.play_ok     = !busy_ff && (req_play_length != '0);
      status.tick_hold   = tick_hold;
      status.seg_started = seg_started;
      status.at_end      = at_end;
   end

   always_comb begin
      busy_in     = busy_ff;
      ptr_in      = ptr_ff;
      end_in      = end_ff;
      phase_on_in = phase_on_ff;
      ticks_in    = ticks_ff;
      pulses_in   = pulses_ff;
      pins_in     = pins_ff;
      acc_in      = acc_ff;
      tick_hold   = 1'b0;
      seg_started = 1'b0;
      do_relax    = 1'b0;
      if (cmd.accept) begin
         acc_in = ((cmd.op == OP_WRITE) && idx_ok) || (cmd.op == OP_PLAY);
      end
      unique case (cmd.op) inside
         OP_NONE, OP_WRITE: begin
         end
         OP_PLAY: begin
            busy_in     = 1'b1;
            ptr_in      = '0;
            phase_on_in = 1'b0;
            ticks_in    = '0;
            pulses_in   = '0;
            if (32'(req_play_length) > 32'(SEGMENT_DEPTH)) begin
               end_in = PTR_W'(SEGMENT_DEPTH);
            end else begin
               end_in = PTR_W'(req_play_length);
            end
         end
         OP_STOP: do_relax = 1'b1;
         OP_TICK_DEC: ticks_in = ticks_ff - TIME_BITS'(1);
         OP_TICK_EVAL: begin
            ticks_in = '0;
            if (!mode_ff) begin
               if (phase_on_ff) begin
                  phase_on_in = 1'b0;
                  pins_in     = '0;
               end
               if (phase_on_ff && (rd_ff.off_ticks != '0)) begin
                  ticks_in  = rd_ff.off_ticks;
                  tick_hold = 1'b1;
               end else if (pulses_ff > TIME_BITS'(1)) begin
                  pulses_in = pulses_ff - TIME_BITS'(1);
                  if (rd_ff.on_ticks != '0) begin
                     pins_in     = FWD_BIT;
                     phase_on_in = 1'b1;
                     ticks_in    = rd_ff.on_ticks;
                     tick_hold   = 1'b1;
                  end else if (rd_ff.off_ticks != '0) begin
                     pins_in     = '0;
                     phase_on_in = 1'b0;
                     ticks_in    = rd_ff.off_ticks;
                     tick_hold   = 1'b1;
                  end else begin
                     pulses_in = '0;
                  end
               end else begin
                  pulses_in = '0;
               end
            end
            if (!tick_hold) begin
               ptr_in = ptr_ff + PTR_W'(1);
            end
         end
         OP_SCAN_EVAL: begin
            if (at_end) begin
               do_relax = 1'b1;
            end else if (!mode_ff) begin
               if (rd_ff.reps != '0) begin
                  pulses_in = rd_ff.reps;
                  if (rd_ff.on_ticks != '0) begin
                     pins_in     = FWD_BIT;
                     phase_on_in = 1'b1;
                     ticks_in    = rd_ff.on_ticks;
                     seg_started = 1'b1;
                  end else if (rd_ff.off_ticks != '0) begin
                     pins_in     = '0;
                     phase_on_in = 1'b0;
                     ticks_in    = rd_ff.off_ticks;
                     seg_started = 1'b1;
                  end
               end
            end else if (rd_ff.on_ticks != '0) begin
               pins_in     = rd_ff.code;
               phase_on_in = 1'b0;
               ticks_in    = rd_ff.on_ticks;
               seg_started = 1'b1;
            end
            // empty segment: move on to the next slot
            if (!at_end && !seg_started) begin
               ptr_in = ptr_ff + PTR_W'(1);
            end
         end
         OP_FINISH: begin
            // rotor mode never drives the reverse pin
            if (!mode_ff) begin
               pins_in = pins_ff & FWD_BIT;
            end
         end
         default: begin
         end
      endcase
      if (do_relax) begin
         busy_in     = 1'b0;
         ptr_in      = '0;
         end_in      = '0;
         phase_on_in = 1'b0;
         ticks_in    = '0;
         pulses_in   = '0;
         pins_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= 1'b0;
         busy_ff     <= 1'b0;
         ptr_ff      <= '0;
         end_ff      <= '0;
         phase_on_ff <= 1'b0;
         ticks_ff    <= '0;
         pulses_ff   <= '0;
         pins_ff     <= '0;
         acc_ff      <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            mode_ff <= csr_wr_data;
         end
         busy_ff     <= busy_in;
         ptr_ff      <= ptr_in;
         end_ff      <= end_in;
         phase_on_ff <= phase_on_in;
         ticks_ff    <= ticks_in;
         pulses_ff   <= pulses_in;
         pins_ff     <= pins_in;
         acc_ff      <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_FINISH) begin
         out_fwd_ff  <= pins_in[0];
         out_rev_ff  <= pins_in[1];
         out_busy_ff <= busy_ff;
         out_acc_ff  <= acc_ff;
         out_cur_ff  <= busy_ff ? CUR_W'(ptr_ff) : '0;
      end
   end

   assign rsp_pin_forward     = out_fwd_ff;
   assign rsp_pin_reverse     = out_rev_ff;
   assign rsp_busy_res        = out_busy_ff;
   assign rsp_accepted        = out_acc_ff;
   assign rsp_current_segment = out_cur_ff;

`ifndef SYNTH
   a_busy_ptr_in_list: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_FINISH) && busy_ff |-> ptr_ff < end_ff)
      else $error("playing with pointer past the list end");
   a_idle_relaxed: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_FINISH) && !busy_ff |-> pins_ff == '0)
      else $error("drive pins active while not playing");
   a_busy_phase_armed: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_FINISH) && busy_ff |-> ticks_ff != '0)
      else $error("playing with no phase ticks left");
   a_tick_eval_busy: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_TICK_EVAL) |-> busy_ff)
      else $error("phase expiry evaluated while not playing");
`endif

endmodule

// ===== hdl/haptic_segment_sequencer_core.sv =====
// haptic segment sequencer top level: controller and datapath
//
//  channel | ports                        | direction | handshake
//  --------+------------------------------+-----------+---------------------
//  request | req_kind .. req_play_length  | in        | req_valid / req_stall
//  result  | rsp_pin_forward .. current   | out       | rsp_valid / rsp_stall
//  config  | csr_wr_data (motor_kind)     | in        | csr_wr_en, no wait
//
// write, stop, refused play and a counting tick go from idle straight to the finish state
// a tick that ends a phase passes tick wait and tick eval, plus a scan wait/eval pair per further slot examined
// and another at list end; a play passes a scan wait/eval pair per slot examined up to the first playable one,
// and another at list end; those wait states come from the single-port table with its registered read
// reset is synchronous; the segment table is not cleared and holds garbage until written
// one result register: a new request is taken while a result waits on rsp_stall
module haptic_segment_sequencer_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [hss_pkg::KIND_W-1:0]    req_kind,
   input  logic [hss_pkg::IDX_W-1:0]     req_seg_index,
   input  logic [hss_pkg::FTIME_W-1:0]   req_on_time,
   input  logic [hss_pkg::FTIME_W-1:0]   req_off_time,
   input  logic [hss_pkg::FTIME_W-1:0]   req_repeat_count,
   input  logic [hss_pkg::CODE_W-1:0]    req_drive_code,
   input  logic [hss_pkg::LEN_W-1:0]     req_play_length,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_pin_forward,
   output logic                          rsp_pin_reverse,
   output logic                          rsp_busy_res,
   output logic                          rsp_accepted,
   output logic [hss_pkg::CUR_W-1:0]     rsp_current_segment,
   input  logic                          csr_wr_en,
   input  logic                          csr_wr_data
);
   import hss_pkg::*;

   cmd_type    cmd;
   status_type status;

   hss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_kind  (req_kind),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   hss_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_seg_index       (req_seg_index),
      .req_on_time         (req_on_time),
      .req_off_time        (req_off_time),
      .req_repeat_count    (req_repeat_count),
      .req_drive_code      (req_drive_code),
      .req_play_length     (req_play_length),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .rsp_pin_forward     (rsp_pin_forward),
      .rsp_pin_reverse     (rsp_pin_reverse),
      .rsp_busy_res        (rsp_busy_res),
      .rsp_accepted        (rsp_accepted),
      .rsp_current_segment (rsp_current_segment)
   );

endmodule

// ===== tb/hss_tb_pkg.sv =====
// request kind and motor mode codes shared by the testbench stimulus and the checker
package hss_tb_pkg;

   typedef enum logic [hss_pkg::KIND_W-1:0] {
      REQ_TICK,
      REQ_WRITE,
      REQ_PLAY,
      REQ_STOP
   } req_kind_type;

   localparam logic MODE_ROTOR  = 1'b0;
   localparam logic MODE_LINEAR = 1'b1;

endpackage

// ===== tb/hss_checker.sv =====
// checker: tracks the sequencer state per transaction and compares every result in order
module hss_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  logic [hss_pkg::KIND_W-1:0]   req_kind,
   input  logic [hss_pkg::IDX_W-1:0]    req_seg_index,
   input  logic [hss_pkg::FTIME_W-1:0]  req_on_time,
   input  logic [hss_pkg::FTIME_W-1:0]  req_off_time,
   input  logic [hss_pkg::FTIME_W-1:0]  req_repeat_count,
   input  logic [hss_pkg::CODE_W-1:0]   req_drive_code,
   input  logic [hss_pkg::LEN_W-1:0]    req_play_length,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  logic                         rsp_pin_forward,
   input  logic                         rsp_pin_reverse,
   input  logic                         rsp_busy_res,
   input  logic                         rsp_accepted,
   input  logic [hss_pkg::CUR_W-1:0]    rsp_current_segment,
   input  logic                         csr_wr_en,
   input  logic                         csr_wr_data,
   output int                           fail_count,
   output int                           open_count,
   output int                           checked_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import hss_pkg::*;
   import hss_tb_pkg::*;

   typedef struct packed {
      logic             fwd;
      logic             rev;
      logic             busy;
      logic             acc;
      logic [CUR_W-1:0] seg;
   } drive_report_type;

   logic                 motor_mode;
   seg_type              seg_mem [SEGMENT_DEPTH];
   logic [PTR_W-1:0]     play_ptr;
   logic [PTR_W-1:0]     play_stop;
   logic                 on_phase;
   logic [TIME_BITS-1:0] ticks_left;
   logic [TIME_BITS-1:0] pulses_left;
   logic                 playing;
   logic [CODE_W-1:0]    pins;

   drive_report_type pending_reports [$];

   function automatic void relax_drive();
      pins        = '0;
      playing     = 1'b0;
      play_ptr    = '0;
      play_stop   = '0;
      on_phase    = 1'b0;
      ticks_left  = '0;
      pulses_left = '0;
   endfunction

   // starts the on phase, or the off phase when there is no on time
   function automatic logic start_pulse(seg_type s);
      if (s.on_ticks != 0) begin
         pins       = FWD_BIT;
         on_phase   = 1'b1;
         ticks_left = s.on_ticks;
         return 1'b1;
      end
      if (s.off_ticks != 0) begin
         pins       = '0;
         on_phase   = 1'b0;
         ticks_left = s.off_ticks;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void seek_segment();
      seg_type s;
      while (play_ptr < play_stop && play_ptr < SEGMENT_DEPTH) begin
         s = seg_mem[play_ptr[ADDR_W-1:0]];
         if (motor_mode == MODE_ROTOR) begin
            if (s.reps != 0) begin
               pulses_left = s.reps;
               if (start_pulse(s)) return;
            end
         end else if (s.on_ticks != 0) begin
            pins       = s.code;
            on_phase   = 1'b0;
            ticks_left = s.on_ticks;
            return;
         end
         play_ptr++;
      end
      relax_drive();
   endfunction

   function automatic void count_tick();
      seg_type s;
      if (!playing) return;
      if (ticks_left > 1) begin
         ticks_left--;
         return;
      end
      ticks_left = '0;
      s = (play_ptr < SEGMENT_DEPTH) ? seg_mem[play_ptr[ADDR_W-1:0]] : seg_mem[0];
      if (motor_mode == MODE_ROTOR) begin
         if (on_phase) begin
            on_phase = 1'b0;
            pins     = '0;
            if (s.off_ticks != 0) begin
               ticks_left = s.off_ticks;
               return;
            end
         end
         if (pulses_left > 1) begin
            pulses_left--;
            if (start_pulse(s)) return;
         end
         pulses_left = '0;
      end
      play_ptr++;
      seek_segment();
   endfunction

   function automatic drive_report_type apply_request();
      drive_report_type r;
      logic [LEN_W-1:0] n;
      r.acc = 1'b0;
      case (req_kind_type'(req_kind))
         REQ_TICK: count_tick();
         REQ_WRITE: begin
            seg_mem[req_seg_index] = '{on_ticks: req_on_time, off_ticks: req_off_time,
                                       reps: req_repeat_count, code: req_drive_code};
            r.acc = 1'b1;
         end
         REQ_PLAY: begin
            n = req_play_length;
            if (!playing && n != 0) begin
               if (n > SEGMENT_DEPTH) n = LEN_W'(SEGMENT_DEPTH);
               r.acc       = 1'b1;
               playing     = 1'b1;
               play_ptr    = '0;
               play_stop   = n;
               on_phase    = 1'b0;
               ticks_left  = '0;
               pulses_left = '0;
               seek_segment();
            end
         end
         default: relax_drive();
      endcase
      if (motor_mode == MODE_ROTOR) pins &= FWD_BIT;
      r.fwd  = pins[0];
      r.rev  = pins[1];
      r.busy = playing;
      r.seg  = playing ? play_ptr[CUR_W-1:0] : '0;
      return r;
   endfunction

   always @(posedge clock) begin : watch
      drive_report_type want;
      drive_report_type got;
      if (reset) begin
         motor_mode = MODE_ROTOR;
         relax_drive();
         pending_reports.delete();
      end else begin
         // the result of a transaction never leaves on the edge that takes it
         if (rsp_valid && !rsp_stall) begin
            got = '{fwd: rsp_pin_forward, rev: rsp_pin_reverse, busy: rsp_busy_res,
                    acc: rsp_accepted, seg: rsp_current_segment};
            if (pending_reports.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display({"%0t: result with nothing pending: ",
                            "fwd=%b rev=%b busy=%b acc=%b seg=%0d"},
                           $realtime, got.fwd, got.rev, got.busy, got.acc, got.seg);
            end else begin
               want = pending_reports.pop_front();
               if (got !== want) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"%0t: result %0d mismatch: expected fwd=%b rev=%b busy=%b ",
                               "acc=%b seg=%0d, got fwd=%b rev=%b busy=%b acc=%b seg=%0d"},
                              $realtime, checked_count, want.fwd, want.rev, want.busy,
                              want.acc, want.seg, got.fwd, got.rev, got.busy, got.acc,
                              got.seg);
               end
               checked_count++;
            end
         end
         if (csr_wr_en) motor_mode = csr_wr_data;
         if (req_valid && !req_stall) pending_reports.push_back(apply_request());
      end
      open_count = pending_reports.size();
   end

endmodule

// ===== tb/tb.sv =====
// testbench top: clock, reset, directed and random segment playback traffic, verdict
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import hss_pkg::*, hss_tb_pkg::*;

   localparam int CYCLE_LIMIT = 4_000_000;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [KIND_W-1:0]  req_kind;
   logic [IDX_W-1:0]   req_seg_index;
   logic [FTIME_W-1:0] req_on_time;
   logic [FTIME_W-1:0] req_off_time;
   logic [FTIME_W-1:0] req_repeat_count;
   logic [CODE_W-1:0]  req_drive_code;
   logic [LEN_W-1:0]   req_play_length;
   logic               rsp_valid;
   logic               rsp_stall;
   logic               rsp_pin_forward;
   logic               rsp_pin_reverse;
   logic               rsp_busy_res;
   logic               rsp_accepted;
   logic [CUR_W-1:0]   rsp_current_segment;
   logic               csr_wr_en;
   logic               csr_wr_data;

   int fail_count;
   int open_count;
   int checked_count;
   int cycle_count;
   int items_sent;
   int kind_sent [4];
   int mode_writes;
   bit calm;

   haptic_segment_sequencer_core DUT (.*);

   hss_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         rsp_stall <= !calm && ($urandom_range(99) < 14);
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d transactions open", cycle_count, open_count);
      $display("FAILURE");
      $finish;
   end

   task automatic send_item(input req_kind_type k, input logic [IDX_W-1:0] idx,
                            input logic [FTIME_W-1:0] on_t, input logic [FTIME_W-1:0] off_t,
                            input logic [FTIME_W-1:0] reps, input logic [CODE_W-1:0] code,
                            input logic [LEN_W-1:0] len);
      @(negedge clock);
      while (!calm && $urandom_range(99) < 14) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_kind         <= k;
      req_seg_index    <= idx;
      req_on_time      <= on_t;
      req_off_time     <= off_t;
      req_repeat_count <= reps;
      req_drive_code   <= code;
      req_play_length  <= len;
      do @(posedge clock); while (req_stall);
      items_sent++;
      kind_sent[k]++;
   endtask

   // mostly short phases so lists finish; now and then a full-range value
   function automatic logic [FTIME_W-1:0] pick_ticks();
      int r;
      r = $urandom_range(99);
      if (r < 80) return FTIME_W'($urandom_range(0, 4));
      if (r < 95) return FTIME_W'($urandom_range(5, 40));
      return FTIME_W'($urandom_range(0, 65535));
   endfunction

   function automatic logic [LEN_W-1:0] pick_length();
      int r;
      r = $urandom_range(99);
      if (r < 8) return '0;
      if (r < 80) return LEN_W'($urandom_range(1, 6));
      if (r < 92) return LEN_W'($urandom_range(7, SEGMENT_DEPTH));
      return LEN_W'($urandom_range(SEGMENT_DEPTH + 1, 255));
   endfunction

   task automatic send_write(input logic [IDX_W-1:0] idx);
      send_item(REQ_WRITE, idx, pick_ticks(), pick_ticks(), pick_ticks(),
                CODE_W'($urandom_range(0, 3)), LEN_W'($urandom));
   endtask

   task automatic send_plain(input req_kind_type k);
      send_item(k, IDX_W'($urandom), FTIME_W'($urandom), FTIME_W'($urandom),
                FTIME_W'($urandom), CODE_W'($urandom), pick_length());
   endtask

   // reprogram a few low slots, start a list and clock it along
   task automatic play_burst();
      int n;
      int r;
      n = $urandom_range(0, 3);
      repeat (n) send_write(IDX_W'($urandom_range(0, 7)));
      send_plain(REQ_PLAY);
      n = $urandom_range(1, 80);
      repeat (n) begin
         r = $urandom_range(99);
         if (r < 5) send_write(IDX_W'($urandom_range(0, SEGMENT_DEPTH - 1)));
         else if (r < 8) send_plain(REQ_PLAY);
         else send_plain(REQ_TICK);
      end
      if ($urandom_range(99) < 15) send_plain(REQ_STOP);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (open_count != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic set_mode(input logic m);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= m;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      mode_writes++;
   endtask

   initial begin
      int phase_end;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_kind         = REQ_TICK;
      req_seg_index    = '0;
      req_on_time      = '0;
      req_off_time     = '0;
      req_repeat_count = '0;
      req_drive_code   = '0;
      req_play_length  = '0;
      csr_wr_en        = 1'b0;
      csr_wr_data      = MODE_ROTOR;
      calm             = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      set_mode(MODE_ROTOR);
      // idle block, refused empty list
      send_item(REQ_TICK, 0, 0, 0, 0, 0, 0);
      send_item(REQ_STOP, 0, 0, 0, 0, 0, 0);
      send_item(REQ_PLAY, 0, 0, 0, 0, 0, 0);
      send_item(REQ_WRITE, 0, 16'd2, 16'd1, 16'd2, 2'd3, 0);
      // pure pause, zero repeats, zero off phase, both times zero
      send_item(REQ_WRITE, 1, 16'd0, 16'd2, 16'd1, 2'd0, 0);
      send_item(REQ_WRITE, 2, 16'hffff, 16'hffff, 16'd0, 2'd2, 0);
      send_item(REQ_WRITE, 3, 16'd1, 16'd0, 16'd2, 2'd1, 0);
      send_item(REQ_WRITE, 4, 16'd0, 16'd0, 16'd3, 2'd3, 0);
      send_item(REQ_WRITE, 7'd127, 16'hffff, 16'hffff, 16'hffff, 2'd3, 8'hff);
      send_item(REQ_PLAY, 0, 0, 0, 0, 0, 8'd5);
      send_item(REQ_PLAY, 0, 0, 0, 0, 0, 8'd3);
      send_item(REQ_WRITE, 1, 16'd1, 16'd1, 16'd1, 2'd1, 0);
      repeat (10) send_item(REQ_TICK, 0, 0, 0, 0, 0, 0);
      send_item(REQ_STOP, 0, 0, 0, 0, 0, 0);
      // a list with nothing playable ends at once
      send_item(REQ_WRITE, 0, 16'd0, 16'd0, 16'd0, 2'd0, 0);
      send_item(REQ_PLAY, 0, 0, 0, 0, 0, 8'd1);

      // every slot written so any list length reads known contents
      for (int i = 0; i < SEGMENT_DEPTH; i++) send_write(IDX_W'(i));

      for (int ph = 0; ph < 6; ph++) begin
         if (ph < 4) set_mode(ph[0] ? MODE_ROTOR : MODE_LINEAR);
         else set_mode(logic'($urandom_range(0, 1)));
         calm = (ph == 2);
         phase_end = items_sent + 265;
         while (items_sent < phase_end) begin
            if ($urandom_range(99) < 70) play_burst();
            else send_plain(req_kind_type'($urandom_range(0, 3)));
         end
      end
      calm = 1'b0;
      drain();
      repeat (20) @(negedge clock);

      $display("covered %0d transactions: %0d ticks, %0d segment writes, %0d plays, %0d stops",
               items_sent, kind_sent[REQ_TICK], kind_sent[REQ_WRITE], kind_sent[REQ_PLAY],
               kind_sent[REQ_STOP]);
      $display("compared %0d results over %0d motor mode writes in %0d cycles",
               checked_count, mode_writes, cycle_count);
      if (fail_count == 0 && open_count == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule
